[design/pat_pkg.sv]
package pat_pkg;

    localparam int INDEX_BITS  = 24;
    localparam int TEX_ID_BITS = 16;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef logic [INDEX_BITS-1:0]  t_index;
    typedef logic [TEX_ID_BITS-1:0] t_tex_id;

    typedef enum logic {
        CMD_BEGIN  = 1'b0,
        CMD_VERTEX = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LIST    = 2'd0,
        KIND_STRIP   = 2'd1,
        KIND_FAN     = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    typedef struct packed {
        logic    vtx;
        logic    emit;
        t_index  index_a;
        t_index  index_b;
        t_index  index_c;
        logic    textured;
        t_tex_id tex_id;
        logic    vwrap;
    } t_work;

    typedef struct packed {
        logic    tri_valid;
        t_index  index_a;
        t_index  index_b;
        t_index  index_c;
        logic    chunk_open;
        t_index  chunk_start;
        logic    chunk_textured;
        t_tex_id chunk_tex_id;
        logic    count_wrapped;
    } t_result;

endpackage

[design/pat_ifs.sv]
interface pat_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [1:0]                 prim_type;
    logic                       textured;
    logic [pat_pkg::TEX_ID_BITS-1:0] tex_id;

    modport source (output valid, output cmd, output prim_type, output textured,
                    output tex_id, input ready);
    modport sink (input valid, input cmd, input prim_type, input textured,
                  input tex_id, output ready);
endinterface

interface pat_out_if;
    logic                            valid;
    logic                            ready;
    logic                            tri_valid;
    logic [pat_pkg::INDEX_BITS-1:0]  index_a;
    logic [pat_pkg::INDEX_BITS-1:0]  index_b;
    logic [pat_pkg::INDEX_BITS-1:0]  index_c;
    logic                            chunk_open;
    logic [pat_pkg::INDEX_BITS-1:0]  chunk_start;
    logic                            chunk_textured;
    logic [pat_pkg::TEX_ID_BITS-1:0] chunk_tex_id;
    logic                            count_wrapped;

    modport source (output valid, output tri_valid, output index_a, output index_b,
                    output index_c, output chunk_open, output chunk_start,
                    output chunk_textured, output chunk_tex_id, output count_wrapped,
                    input ready);
    modport sink (input valid, input tri_valid, input index_a, input index_b,
                  input index_c, input chunk_open, input chunk_start,
                  input chunk_textured, input chunk_tex_id, input count_wrapped,
                  output ready);
endinterface

[design/primitive_assembly_triangles.sv]
// Triangle assembly for list, strip and fan primitives with material chunk tracking.
// The block takes one request per clock and delivers exactly one result per request
// via a front stage, a two-entry queue and a back stage: the front stage assigns the
// vertex index and forms the triangle from the running vertex count, the queue carries
// the request, and the back stage updates the triangle count and the open chunk and
// holds the result in an output register. Both sides may stall freely; input ready
// drops only when the queue holds two requests that the output has not taken.
// Counters wrap at their width and the wrap flag stays set until reset.
module primitive_assembly_triangles (
    input logic       i_clk,
    input logic       i_rst_n,
    pat_in_if.sink    i_in,
    pat_out_if.source o_out
);

    logic           push, space, q_valid, pop;
    pat_pkg::t_work push_work, head_work;

    pat_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_work  (push_work),
        .i_space (space)
    );

    pat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_space (space),
        .o_valid (q_valid),
        .o_work  (head_work),
        .i_pop   (pop)
    );

    pat_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_work  (head_work),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[design/pat_front.sv]
module pat_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pat_in_if.sink         i_in,
    output logic           o_push,
    output pat_pkg::t_work o_work,
    input  logic           i_space
);

    pat_pkg::t_index r_vtotal, n_vtotal;
    pat_pkg::t_index r_base, n_base;
    pat_pkg::t_index r_len, n_len;
    pat_pkg::t_kind  r_kind, n_kind;
    logic [1:0]      r_mod3, n_mod3;
    logic            accept;
    logic            long_enough;
    pat_pkg::t_work  work;

    assign i_in.ready = i_space;
    assign accept     = i_in.valid && i_space;

    always_comb begin
        n_vtotal    = r_vtotal;
        n_base      = r_base;
        n_len       = r_len;
        n_kind      = r_kind;
        n_mod3      = r_mod3;
        work        = '0;
        long_enough = 1'b0;
        if (pat_pkg::t_cmd'(i_in.cmd) == pat_pkg::CMD_BEGIN) begin
            n_kind = pat_pkg::t_kind'(i_in.prim_type);
            n_base = r_vtotal;
            n_len  = '0;
            n_mod3 = 2'd0;
        end else begin
            n_vtotal = r_vtotal + pat_pkg::INDEX_BITS'(1);
            n_len    = r_len + pat_pkg::INDEX_BITS'(1);
            if (n_len == '0 || r_mod3 == 2'd2) begin
                n_mod3 = 2'd0;
            end else begin
                n_mod3 = r_mod3 + 2'd1;
            end
            long_enough   = n_len >= pat_pkg::INDEX_BITS'(3);
            work.vtx      = 1'b1;
            work.textured = i_in.textured;
            work.tex_id   = i_in.tex_id;
            work.vwrap    = n_vtotal == '0;
            if (long_enough) begin
                unique case (r_kind)
                    pat_pkg::KIND_LIST: begin
                        work.emit = n_mod3 == 2'd0;
                    end
                    pat_pkg::KIND_STRIP,
                    pat_pkg::KIND_FAN: begin
                        work.emit = 1'b1;
                    end
                    default: begin
                        work.emit = 1'b0;
                    end
                endcase
            end
            if (work.emit) begin
                work.index_c = r_vtotal;
                work.index_b = r_vtotal - pat_pkg::INDEX_BITS'(1);
                work.index_a = r_vtotal - pat_pkg::INDEX_BITS'(2);
                if (r_kind == pat_pkg::KIND_FAN) begin
                    work.index_a = r_base;
                end else if (r_kind == pat_pkg::KIND_STRIP && !n_len[0]) begin
                    work.index_a = r_vtotal - pat_pkg::INDEX_BITS'(1);
                    work.index_b = r_vtotal - pat_pkg::INDEX_BITS'(2);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtotal <= '0;
            r_base   <= '0;
            r_len    <= '0;
            r_kind   <= pat_pkg::KIND_UNKNOWN;
            r_mod3   <= 2'd0;
        end else if (accept) begin
            r_vtotal <= n_vtotal;
            r_base   <= n_base;
            r_len    <= n_len;
            r_kind   <= n_kind;
            r_mod3   <= n_mod3;
        end
    end

    assign o_push = accept;
    assign o_work = work;

`ifndef SYNTHESIS
    a_begin_clears_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pat_pkg::t_cmd'(i_in.cmd) == pat_pkg::CMD_BEGIN
        |=> r_len == '0 && r_mod3 == 2'd0)
        else $error("primitive length not cleared by begin request");
`endif

endmodule

[design/pat_queue.sv]
module pat_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pat_pkg::t_work i_work,
    output logic           o_space,
    output logic           o_valid,
    output pat_pkg::t_work o_work,
    input  logic           i_pop
);

    pat_pkg::t_work                   r_mem [pat_pkg::Q_DEPTH];
    logic [pat_pkg::Q_PTR_BITS-1:0]   r_wptr, r_rptr;
    logic [pat_pkg::Q_CNT_BITS-1:0]   r_count;
    logic                             do_push, do_pop;

    assign o_space = r_count != pat_pkg::Q_CNT_BITS'(pat_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_work  = r_mem[r_rptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == pat_pkg::Q_PTR_BITS'(pat_pkg::Q_DEPTH - 1)) ?
                          '0 : r_wptr + pat_pkg::Q_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == pat_pkg::Q_PTR_BITS'(pat_pkg::Q_DEPTH - 1)) ?
                          '0 : r_rptr + pat_pkg::Q_PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + pat_pkg::Q_CNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - pat_pkg::Q_CNT_BITS'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pat_pkg::Q_CNT_BITS'(pat_pkg::Q_DEPTH))
        else $error("queue count beyond depth");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_space && !do_pop |=> !o_space && $stable(r_wptr))
        else $error("queue accepted a request while full");
`endif

endmodule

[design/pat_back.sv]
module pat_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pat_pkg::t_work i_work,
    output logic           o_pop,
    pat_out_if.source      o_out
);

    pat_pkg::t_index  r_tri;
    logic             r_wrap;
    logic             r_cvalid;
    logic             r_ctex;
    pat_pkg::t_tex_id r_cname;
    logic             r_out_valid;
    pat_pkg::t_result r_out, n_out;
    pat_pkg::t_index  n_tri;
    logic             pop, change, tri_hit;

    assign pop     = i_valid && (!r_out_valid || o_out.ready);
    assign tri_hit = i_work.vtx && i_work.emit;
    assign change  = i_work.vtx && (!r_cvalid || r_ctex != i_work.textured ||
                                    r_cname != i_work.tex_id);
    assign n_tri   = r_tri + pat_pkg::INDEX_BITS'(1);

    always_comb begin
        n_out               = '0;
        n_out.tri_valid     = tri_hit;
        n_out.index_a       = i_work.index_a;
        n_out.index_b       = i_work.index_b;
        n_out.index_c       = i_work.index_c;
        n_out.count_wrapped = r_wrap || i_work.vwrap || (tri_hit && n_tri == '0);
        if (change) begin
            n_out.chunk_open     = 1'b1;
            n_out.chunk_start    = r_tri;
            n_out.chunk_textured = i_work.textured;
            n_out.chunk_tex_id   = i_work.tex_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri       <= '0;
            r_wrap      <= 1'b0;
            r_cvalid    <= 1'b0;
            r_ctex      <= 1'b0;
            r_cname     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= 1'b1;
                r_wrap      <= n_out.count_wrapped;
                if (tri_hit) begin
                    r_tri <= n_tri;
                end
                if (change) begin
                    r_cvalid <= 1'b1;
                    r_ctex   <= i_work.textured;
                    r_cname  <= i_work.tex_id;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_pop                = pop;
    assign o_out.valid          = r_out_valid;
    assign o_out.tri_valid      = r_out.tri_valid;
    assign o_out.index_a        = r_out.index_a;
    assign o_out.index_b        = r_out.index_b;
    assign o_out.index_c        = r_out.index_c;
    assign o_out.chunk_open     = r_out.chunk_open;
    assign o_out.chunk_start    = r_out.chunk_start;
    assign o_out.chunk_textured = r_out.chunk_textured;
    assign o_out.chunk_tex_id   = r_out.chunk_tex_id;
    assign o_out.count_wrapped  = r_out.count_wrapped;

`ifndef SYNTHESIS
    a_chunk_after_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_work.vtx |=> r_cvalid)
        else $error("no chunk open after a vertex request");
    a_tri_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tri_valid |->
        r_out.index_c == r_out.index_b + pat_pkg::INDEX_BITS'(1) ||
        r_out.index_c == r_out.index_a + pat_pkg::INDEX_BITS'(1))
        else $error("triangle indices are not consecutive");
`endif

endmodule
